// ----- rtl/core/pgss_pkg.sv -----
package pgss_pkg;

  localparam int MAX_POINTS = 64;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PTR_W + 1;
  localparam int COORD_W    = 32;
  localparam int SPC_W      = 31;
  localparam int ICNT_W     = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int LANES      = 4;
  localparam int DIV_STEPS  = COORD_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int PROD_W     = 2 * COORD_W;

  localparam logic [2:0] REG_X_SPACING    = 3'd0;
  localparam logic [2:0] REG_Y_SPACING    = 3'd1;
  localparam logic [2:0] REG_Z_SPACING    = 3'd2;
  localparam logic [2:0] REG_M_SPACING    = 3'd3;
  localparam logic [2:0] REG_HAS_Z        = 3'd4;
  localparam logic [2:0] REG_HAS_M        = 3'd5;
  localparam logic [2:0] REG_DROP_COLLIN  = 3'd6;

  typedef struct packed {
    logic [SPC_W-1:0] x_sp;
    logic [SPC_W-1:0] y_sp;
    logic [SPC_W-1:0] z_sp;
    logic [SPC_W-1:0] m_sp;
    logic             has_z;
    logic             has_m;
    logic             drop_col;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    logic [COORD_W-1:0] rz;
    logic [COORD_W-1:0] rm;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
    logic [COORD_W-1:0] raw_z;
    logic               final_v;
  } vtx_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [COORD_W-1:0] m;
  } point_t;

  typedef struct packed {
    logic done;
    logic hit;
  } coln_sts_t;

endpackage

// ----- rtl/core/pgss_ram.sv -----
module pgss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/pgss_snap.sv -----
module pgss_snap (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pgss_pkg::cfg_t                    cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_x,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_y,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_z,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_m,
  input  logic                              in_final_vertex,
  output logic                              q_valid,
  input  logic                              q_ready,
  output pgss_pkg::vtx_t                    q_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_FIN  = 4'b0100,
    S_PUSH = 4'b1000
  } snap_state_t;

  snap_state_t state_r, state_nxt;

  logic [pgss_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W-1:0] val_r, val_nxt;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W-1:0] sh_r, sh_nxt;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::SPC_W-1:0]   rem_r, rem_nxt;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W:0]   mag_r, mag_nxt;
  logic                         fin_r, fin_nxt;

  logic [pgss_pkg::LANES-1:0][pgss_pkg::SPC_W-1:0]   spc;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W-1:0] abs_v;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W-1:0] res;
  logic [pgss_pkg::LANES-1:0][pgss_pkg::COORD_W-1:0] in_v;

  assign spc[0] = cfg.x_sp;
  assign spc[1] = cfg.y_sp;
  assign spc[2] = cfg.z_sp;
  assign spc[3] = cfg.m_sp;

  // z and m enter as zero when absent, so they snap to zero as well
  assign in_v[0] = in_x;
  assign in_v[1] = in_y;
  assign in_v[2] = cfg.has_z ? in_z : '0;
  assign in_v[3] = cfg.has_m ? in_m : '0;

  always_comb begin
    for (int i = 0; i < pgss_pkg::LANES; i++) begin
      abs_v[i] = val_r[i][pgss_pkg::COORD_W-1] ? (~val_r[i] + 1'b1) : val_r[i];
      if (spc[i] == '0) begin
        res[i] = val_r[i];
      end else if (!val_r[i][pgss_pkg::COORD_W-1]) begin
        res[i] = (mag_r[i] > {2'b00, {(pgss_pkg::COORD_W-1){1'b1}}}) ?
                 {1'b0, {(pgss_pkg::COORD_W-1){1'b1}}} : mag_r[i][pgss_pkg::COORD_W-1:0];
      end else begin
        res[i] = (mag_r[i] > {2'b01, {(pgss_pkg::COORD_W-1){1'b0}}}) ?
                 {1'b1, {(pgss_pkg::COORD_W-1){1'b0}}} :
                 (~mag_r[i][pgss_pkg::COORD_W-1:0] + 1'b1);
      end
    end
  end

  always_comb begin
    logic [pgss_pkg::COORD_W-1:0] trial;
    logic [pgss_pkg::COORD_W:0]   base;
    state_nxt = state_r;
    step_nxt  = step_r;
    val_nxt   = val_r;
    sh_nxt    = sh_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    fin_nxt   = fin_r;
    trial     = '0;
    base      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < pgss_pkg::LANES; i++) begin
            val_nxt[i] = in_v[i];
            sh_nxt[i]  = in_v[i][pgss_pkg::COORD_W-1] ? (~in_v[i] + 1'b1) : in_v[i];
            rem_nxt[i] = '0;
          end
          fin_nxt   = in_final_vertex;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one remainder bit per cycle in each lane
        for (int i = 0; i < pgss_pkg::LANES; i++) begin
          trial = {rem_r[i], sh_r[i][pgss_pkg::COORD_W-1]};
          if (trial >= {1'b0, spc[i]}) begin
            rem_nxt[i] = pgss_pkg::SPC_W'(trial - {1'b0, spc[i]});
          end else begin
            rem_nxt[i] = trial[pgss_pkg::SPC_W-1:0];
          end
          sh_nxt[i] = {sh_r[i][pgss_pkg::COORD_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == pgss_pkg::STEP_W'(pgss_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // q*s is the magnitude less the remainder; a round-up adds one step
        for (int i = 0; i < pgss_pkg::LANES; i++) begin
          base = {1'b0, abs_v[i]} - {2'b00, rem_r[i]};
          if ({rem_r[i], 1'b0} >= {1'b0, spc[i]}) begin
            mag_nxt[i] = base + {2'b00, spc[i]};
          end else begin
            mag_nxt[i] = base;
          end
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (q_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    val_r  <= val_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    mag_r  <= mag_nxt;
    fin_r  <= fin_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_PUSH);

  always_comb begin
    q_data.rx      = res[0];
    q_data.ry      = res[1];
    q_data.rz      = res[2];
    q_data.rm      = res[3];
    q_data.raw_x   = val_r[0];
    q_data.raw_y   = val_r[1];
    q_data.raw_z   = val_r[2];
    q_data.final_v = fin_r;
  end

endmodule

// ----- rtl/core/pgss_queue.sv -----
module pgss_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pgss_pkg::vtx_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pgss_pkg::vtx_t pop_data
);

  pgss_pkg::vtx_t ent_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/pgss_coline.sv -----
module pgss_coline (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pgss_pkg::COORD_W-1:0] px,
  input  logic [pgss_pkg::COORD_W-1:0] py,
  input  logic [pgss_pkg::COORD_W-1:0] ax,
  input  logic [pgss_pkg::COORD_W-1:0] ay,
  input  logic [pgss_pkg::COORD_W-1:0] bx,
  input  logic [pgss_pkg::COORD_W-1:0] by,
  output pgss_pkg::coln_sts_t          sts
);

  // (px-ax)*(by-ay) against (bx-ax)*(py-ay), two shift-add multipliers
  logic                          busy_r, fin_r;
  logic [pgss_pkg::STEP_W-1:0]   cnt_r;
  logic [pgss_pkg::PROD_W-1:0]   mc1_r, mc2_r, acc1_r, acc2_r;
  logic [pgss_pkg::COORD_W-1:0]  ml1_r, ml2_r;
  logic                          sg1_r, sg2_r;

  logic [pgss_pkg::COORD_W:0]    d1, d2, d3, d4;
  logic [pgss_pkg::COORD_W-1:0]  m1, m2, m3, m4;
  logic                          n1, n2;

  assign d1 = {px[pgss_pkg::COORD_W-1], px} - {ax[pgss_pkg::COORD_W-1], ax};
  assign d2 = {by[pgss_pkg::COORD_W-1], by} - {ay[pgss_pkg::COORD_W-1], ay};
  assign d3 = {bx[pgss_pkg::COORD_W-1], bx} - {ax[pgss_pkg::COORD_W-1], ax};
  assign d4 = {py[pgss_pkg::COORD_W-1], py} - {ay[pgss_pkg::COORD_W-1], ay};

  assign m1 = d1[pgss_pkg::COORD_W] ? pgss_pkg::COORD_W'(~d1 + 1'b1) : d1[pgss_pkg::COORD_W-1:0];
  assign m2 = d2[pgss_pkg::COORD_W] ? pgss_pkg::COORD_W'(~d2 + 1'b1) : d2[pgss_pkg::COORD_W-1:0];
  assign m3 = d3[pgss_pkg::COORD_W] ? pgss_pkg::COORD_W'(~d3 + 1'b1) : d3[pgss_pkg::COORD_W-1:0];
  assign m4 = d4[pgss_pkg::COORD_W] ? pgss_pkg::COORD_W'(~d4 + 1'b1) : d4[pgss_pkg::COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == pgss_pkg::STEP_W'(pgss_pkg::COORD_W - 1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
    if (start) begin
      mc1_r  <= {{pgss_pkg::COORD_W{1'b0}}, m1};
      mc2_r  <= {{pgss_pkg::COORD_W{1'b0}}, m3};
      ml1_r  <= m2;
      ml2_r  <= m4;
      sg1_r  <= d1[pgss_pkg::COORD_W] ^ d2[pgss_pkg::COORD_W];
      sg2_r  <= d3[pgss_pkg::COORD_W] ^ d4[pgss_pkg::COORD_W];
      acc1_r <= '0;
      acc2_r <= '0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      if (ml1_r[0]) begin
        acc1_r <= acc1_r + mc1_r;
      end
      if (ml2_r[0]) begin
        acc2_r <= acc2_r + mc2_r;
      end
      mc1_r <= {mc1_r[pgss_pkg::PROD_W-2:0], 1'b0};
      mc2_r <= {mc2_r[pgss_pkg::PROD_W-2:0], 1'b0};
      ml1_r <= {1'b0, ml1_r[pgss_pkg::COORD_W-1:1]};
      ml2_r <= {1'b0, ml2_r[pgss_pkg::COORD_W-1:1]};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // a zero product has no sign
  assign n1 = (acc1_r != '0) && sg1_r;
  assign n2 = (acc2_r != '0) && sg2_r;

  assign sts.done = fin_r;
  assign sts.hit  = (acc1_r == acc2_r) && (n1 == n2);

endmodule

// ----- rtl/core/pgss_back.sv -----
module pgss_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pgss_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  pgss_pkg::vtx_t                q_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pgss_pkg::COORD_W-1:0] out_x,
  output logic signed [pgss_pkg::COORD_W-1:0] out_y,
  output logic signed [pgss_pkg::COORD_W-1:0] out_z,
  output logic signed [pgss_pkg::COORD_W-1:0] out_m,
  output logic                          out_carries_point,
  output logic                          out_end_of_run,
  output logic                          out_geometry_ok,
  output logic                          out_overflowed
);

  typedef enum logic [13:0] {
    B_IDLE    = 14'b00000000000001,
    B_TEST    = 14'b00000000000010,
    B_VRD1    = 14'b00000000000100,
    B_VRD2    = 14'b00000000001000,
    B_VCOL    = 14'b00000000010000,
    B_COMMIT  = 14'b00000000100000,
    B_FIN     = 14'b00000001000000,
    B_RRD1    = 14'b00000010000000,
    B_RRD2    = 14'b00000100000000,
    B_RRD3    = 14'b00001000000000,
    B_RCOL    = 14'b00010000000000,
    B_EMIT_RD = 14'b00100000000000,
    B_EMIT_LD = 14'b01000000000000,
    B_STATUS  = 14'b10000000000000
  } back_state_t;

  localparam int CW = pgss_pkg::COORD_W;

  back_state_t state_r, state_nxt;

  pgss_pkg::vtx_t                 cur_r, cur_nxt;
  logic [pgss_pkg::CNT_W-1:0]     kcnt_r, kcnt_nxt;
  logic [pgss_pkg::ICNT_W-1:0]    icnt_r, icnt_nxt;
  logic [3:0][CW-1:0]             prev_r, prev_nxt;
  logic [2:0][CW-1:0]             first_r, first_nxt;
  logic                           ovf_r, ovf_nxt;
  logic                           app_r, app_nxt;
  logic                           repl_r, repl_nxt;
  logic                           same_r, same_nxt;
  logic [CW-1:0]                  px_r, py_r, ax_r, ay_r, bx_r, by_r;
  logic [CW-1:0]                  px_nxt, py_nxt, ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic                           start_r, start_nxt;
  logic                           rmv_r, rmv_nxt;
  logic                           ok_r, ok_nxt;
  logic                           eovf_r, eovf_nxt;
  logic [pgss_pkg::CNT_W-1:0]     ecnt_r, ecnt_nxt;
  logic [pgss_pkg::CNT_W-1:0]     k_r, k_nxt;

  logic                           ov_r, ov_nxt;
  pgss_pkg::point_t               op_r, op_nxt;
  logic                           opt_r, opt_nxt, oend_r, oend_nxt;
  logic                           ook_r, ook_nxt, oovf_r, oovf_nxt;

  logic                           we, re;
  logic [pgss_pkg::PTR_W-1:0]     waddr, raddr;
  pgss_pkg::point_t               wdata, rdata;
  pgss_pkg::coln_sts_t            coln;

  logic                           flat, first_v, same, closed, ring, slot_free, last;
  logic [pgss_pkg::CNT_W-1:0]     idx;

  pgss_ram #(
    .WIDTH ($bits(pgss_pkg::point_t)),
    .DEPTH (pgss_pkg::MAX_POINTS)
  ) u_kept (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  pgss_coline u_coline (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .px    (px_r),
    .py    (py_r),
    .ax    (ax_r),
    .ay    (ay_r),
    .bx    (bx_r),
    .by    (by_r),
    .sts   (coln)
  );

  assign flat    = !cfg.has_z && !cfg.has_m;
  assign first_v = (icnt_r == '0);
  assign same    = (cur_r.rx == prev_r[0]) && (cur_r.ry == prev_r[1]) &&
                   (!cfg.has_z || cfg.z_sp == '0 || cur_r.rz == prev_r[2]) &&
                   (!cfg.has_m || cfg.m_sp == '0 || cur_r.rm == prev_r[3]);
  assign closed  = (first_r[0] == cur_r.raw_x) && (first_r[1] == cur_r.raw_y) &&
                   (!cfg.has_z || first_r[2] == cur_r.raw_z);
  assign ring    = cfg.drop_col && closed && flat && (kcnt_r > pgss_pkg::CNT_W'(4));
  assign slot_free = !ov_r || out_ready;
  assign last    = (k_r == ecnt_r - 1'b1);
  // after ring removal vertex 0 is dropped; the ring starts at vertex 1 and closes on it
  assign idx     = rmv_r ? (last ? pgss_pkg::CNT_W'(1) : k_r + 1'b1) : k_r;

  assign q_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    kcnt_nxt  = kcnt_r;
    icnt_nxt  = icnt_r;
    prev_nxt  = prev_r;
    first_nxt = first_r;
    ovf_nxt   = ovf_r;
    app_nxt   = app_r;
    repl_nxt  = repl_r;
    same_nxt  = same_r;
    px_nxt = px_r; py_nxt = py_r;
    ax_nxt = ax_r; ay_nxt = ay_r;
    bx_nxt = bx_r; by_nxt = by_r;
    start_nxt = 1'b0;
    rmv_nxt   = rmv_r;
    ok_nxt    = ok_r;
    eovf_nxt  = eovf_r;
    ecnt_nxt  = ecnt_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ready;
    op_nxt    = op_r;
    opt_nxt   = opt_r;
    oend_nxt  = oend_r;
    ook_nxt   = ook_r;
    oovf_nxt  = oovf_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          cur_nxt   = q_data;
          state_nxt = B_TEST;
        end
      end
      B_TEST: begin
        same_nxt = !first_v && same;
        app_nxt  = first_v || !same;
        repl_nxt = 1'b0;
        if (!first_v && !same && cfg.drop_col && flat && kcnt_r > pgss_pkg::CNT_W'(1)) begin
          re        = 1'b1;
          raddr     = pgss_pkg::PTR_W'(kcnt_r - 1'b1);
          state_nxt = B_VRD1;
        end else begin
          state_nxt = B_COMMIT;
        end
      end
      B_VRD1: begin
        px_nxt    = rdata.x;
        py_nxt    = rdata.y;
        re        = 1'b1;
        raddr     = pgss_pkg::PTR_W'(kcnt_r - pgss_pkg::CNT_W'(2));
        state_nxt = B_VRD2;
      end
      B_VRD2: begin
        ax_nxt    = rdata.x;
        ay_nxt    = rdata.y;
        bx_nxt    = cur_r.rx;
        by_nxt    = cur_r.ry;
        start_nxt = 1'b1;
        state_nxt = B_VCOL;
      end
      B_VCOL: begin
        if (coln.done) begin
          repl_nxt  = coln.hit;
          app_nxt   = !coln.hit;
          state_nxt = B_COMMIT;
        end
      end
      B_COMMIT: begin
        if (first_v) begin
          first_nxt[0] = cur_r.raw_x;
          first_nxt[1] = cur_r.raw_y;
          first_nxt[2] = cur_r.raw_z;
        end
        wdata = '{x: cur_r.rx, y: cur_r.ry, z: cur_r.rz, m: cur_r.rm};
        if (app_r) begin
          if (kcnt_r >= pgss_pkg::CNT_W'(pgss_pkg::MAX_POINTS)) begin
            ovf_nxt = 1'b1;
          end else begin
            we       = 1'b1;
            waddr    = kcnt_r[pgss_pkg::PTR_W-1:0];
            kcnt_nxt = kcnt_r + 1'b1;
          end
        end else if (repl_r) begin
          we    = 1'b1;
          waddr = pgss_pkg::PTR_W'(kcnt_r - 1'b1);
        end
        if (!same_r) begin
          prev_nxt[0] = cur_r.rx;
          prev_nxt[1] = cur_r.ry;
          prev_nxt[2] = cur_r.rz;
          prev_nxt[3] = cur_r.rm;
        end
        if (icnt_r != '1) begin
          icnt_nxt = icnt_r + 1'b1;
        end
        state_nxt = cur_r.final_v ? B_FIN : B_IDLE;
      end
      B_FIN: begin
        ok_nxt   = (kcnt_r >= pgss_pkg::CNT_W'(4)) ||
                   (!closed && kcnt_r >= pgss_pkg::CNT_W'(2));
        eovf_nxt = ovf_r;
        rmv_nxt  = 1'b0;
        ecnt_nxt = kcnt_r;
        k_nxt    = '0;
        if (icnt_r < pgss_pkg::ICNT_W'(2) || kcnt_r == '0) begin
          state_nxt = B_STATUS;
        end else if (ring) begin
          re        = 1'b1;
          raddr     = '0;
          state_nxt = B_RRD1;
        end else begin
          state_nxt = B_EMIT_RD;
        end
      end
      B_RRD1: begin
        px_nxt    = rdata.x;
        py_nxt    = rdata.y;
        re        = 1'b1;
        raddr     = pgss_pkg::PTR_W'(kcnt_r - pgss_pkg::CNT_W'(2));
        state_nxt = B_RRD2;
      end
      B_RRD2: begin
        ax_nxt    = rdata.x;
        ay_nxt    = rdata.y;
        re        = 1'b1;
        raddr     = pgss_pkg::PTR_W'(1);
        state_nxt = B_RRD3;
      end
      B_RRD3: begin
        bx_nxt    = rdata.x;
        by_nxt    = rdata.y;
        start_nxt = 1'b1;
        state_nxt = B_RCOL;
      end
      B_RCOL: begin
        if (coln.done) begin
          rmv_nxt   = coln.hit;
          ecnt_nxt  = coln.hit ? kcnt_r - 1'b1 : kcnt_r;
          state_nxt = B_EMIT_RD;
        end
      end
      B_EMIT_RD: begin
        re        = 1'b1;
        raddr     = idx[pgss_pkg::PTR_W-1:0];
        state_nxt = B_EMIT_LD;
      end
      B_EMIT_LD: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          op_nxt   = rdata;
          opt_nxt  = 1'b1;
          oend_nxt = last;
          ook_nxt  = ok_r;
          oovf_nxt = eovf_r;
          if (last) begin
            kcnt_nxt  = '0;
            icnt_nxt  = '0;
            prev_nxt  = '0;
            first_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = B_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = B_EMIT_RD;
          end
        end
      end
      B_STATUS: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          op_nxt    = '0;
          opt_nxt   = 1'b0;
          oend_nxt  = 1'b1;
          ook_nxt   = 1'b0;
          oovf_nxt  = 1'b0;
          kcnt_nxt  = '0;
          icnt_nxt  = '0;
          prev_nxt  = '0;
          first_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      kcnt_r  <= '0;
      icnt_r  <= '0;
      prev_r  <= '0;
      first_r <= '0;
      ovf_r   <= 1'b0;
      start_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kcnt_r  <= kcnt_nxt;
      icnt_r  <= icnt_nxt;
      prev_r  <= prev_nxt;
      first_r <= first_nxt;
      ovf_r   <= ovf_nxt;
      start_r <= start_nxt;
      ov_r    <= ov_nxt;
    end
    cur_r  <= cur_nxt;
    app_r  <= app_nxt;
    repl_r <= repl_nxt;
    same_r <= same_nxt;
    px_r <= px_nxt; py_r <= py_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt;
    bx_r <= bx_nxt; by_r <= by_nxt;
    rmv_r  <= rmv_nxt;
    ok_r   <= ok_nxt;
    eovf_r <= eovf_nxt;
    ecnt_r <= ecnt_nxt;
    k_r    <= k_nxt;
    op_r   <= op_nxt;
    opt_r  <= opt_nxt;
    oend_r <= oend_nxt;
    ook_r  <= ook_nxt;
    oovf_r <= oovf_nxt;
  end

  assign out_valid         = ov_r;
  assign out_x             = op_r.x;
  assign out_y             = op_r.y;
  assign out_z             = op_r.z;
  assign out_m             = op_r.m;
  assign out_carries_point = opt_r;
  assign out_end_of_run    = oend_r;
  assign out_geometry_ok   = ook_r;
  assign out_overflowed    = oovf_r;

endmodule

// ----- rtl/core/polyline_grid_snap_simplify.sv -----
// Polyline grid snap and simplify. Vertices go in one per transfer; nothing comes
// out until the vertex flagged final, which releases the kept vertices (or one
// status transfer when the run is too short). The front end rounds all four
// coordinates in parallel with a bit-serial remainder, so it takes a new vertex
// only once the last one has gone to the queue. The back end waits for the serial
// multiply of the collinear test when that test runs; a two-entry queue lets the
// front work on the next vertex meanwhile. On the final vertex the back end may
// run the closed-ring test, then emits the kept points one after another. Up to 64
// vertices are buffered; further ones are dropped and flagged. No clearing pass after
// reset. The user must write registers only while the block is idle; it does not check.
module polyline_grid_snap_simplify (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pgss_pkg::ADDR_W-1:0]         paddr,
  input  logic [pgss_pkg::DATA_W-1:0]         pwdata,
  output logic [pgss_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_x,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_y,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_z,
  input  logic signed [pgss_pkg::COORD_W-1:0] in_m,
  input  logic                                in_final_vertex,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pgss_pkg::COORD_W-1:0] out_x,
  output logic signed [pgss_pkg::COORD_W-1:0] out_y,
  output logic signed [pgss_pkg::COORD_W-1:0] out_z,
  output logic signed [pgss_pkg::COORD_W-1:0] out_m,
  output logic                                out_carries_point,
  output logic                                out_end_of_run,
  output logic                                out_geometry_ok,
  output logic                                out_overflowed
);

  pgss_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  logic           fq_valid, fq_ready, bq_valid, bq_ready;
  pgss_pkg::vtx_t fq_data, bq_data;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        pgss_pkg::REG_X_SPACING:   cfg_r.x_sp     <= pwdata[pgss_pkg::SPC_W-1:0];
        pgss_pkg::REG_Y_SPACING:   cfg_r.y_sp     <= pwdata[pgss_pkg::SPC_W-1:0];
        pgss_pkg::REG_Z_SPACING:   cfg_r.z_sp     <= pwdata[pgss_pkg::SPC_W-1:0];
        pgss_pkg::REG_M_SPACING:   cfg_r.m_sp     <= pwdata[pgss_pkg::SPC_W-1:0];
        pgss_pkg::REG_HAS_Z:       cfg_r.has_z    <= pwdata[0];
        pgss_pkg::REG_HAS_M:       cfg_r.has_m    <= pwdata[0];
        pgss_pkg::REG_DROP_COLLIN: cfg_r.drop_col <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pgss_pkg::REG_X_SPACING:   prdata = {1'b0, cfg_r.x_sp};
      pgss_pkg::REG_Y_SPACING:   prdata = {1'b0, cfg_r.y_sp};
      pgss_pkg::REG_Z_SPACING:   prdata = {1'b0, cfg_r.z_sp};
      pgss_pkg::REG_M_SPACING:   prdata = {1'b0, cfg_r.m_sp};
      pgss_pkg::REG_HAS_Z:       prdata = {{(pgss_pkg::DATA_W-1){1'b0}}, cfg_r.has_z};
      pgss_pkg::REG_HAS_M:       prdata = {{(pgss_pkg::DATA_W-1){1'b0}}, cfg_r.has_m};
      pgss_pkg::REG_DROP_COLLIN: prdata = {{(pgss_pkg::DATA_W-1){1'b0}}, cfg_r.drop_col};
      default:                   prdata = '0;
    endcase
  end

  pgss_snap u_snap (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_z            (in_z),
    .in_m            (in_m),
    .in_final_vertex (in_final_vertex),
    .q_valid         (fq_valid),
    .q_ready         (fq_ready),
    .q_data          (fq_data)
  );

  pgss_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (bq_valid),
    .pop_ready  (bq_ready),
    .pop_data   (bq_data)
  );

  pgss_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (bq_valid),
    .q_ready           (bq_ready),
    .q_data            (bq_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .out_m             (out_m),
    .out_carries_point (out_carries_point),
    .out_end_of_run    (out_end_of_run),
    .out_geometry_ok   (out_geometry_ok),
    .out_overflowed    (out_overflowed)
  );

endmodule

// ----- rtl/core/pgss_checker.sv -----
module pgss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         pready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pgss_pkg::COORD_W-1:0] out_x,
  input logic [pgss_pkg::COORD_W-1:0] out_y,
  input logic                         out_carries_point,
  input logic                         out_end_of_run,
  input logic                         out_geometry_ok,
  input logic                         out_overflowed
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y) &&
    $stable(out_end_of_run))
    else $error("result changed while stalled");

  a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_carries_point |-> out_end_of_run)
    else $error("status transfer without end of run");

  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_carries_point |->
    !out_geometry_ok && !out_overflowed && out_x == '0 && out_y == '0)
    else $error("status transfer carries data");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind polyline_grid_snap_simplify pgss_checker u_pgss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .pready            (pready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_x             (out_x),
  .out_y             (out_y),
  .out_carries_point (out_carries_point),
  .out_end_of_run    (out_end_of_run),
  .out_geometry_ok   (out_geometry_ok),
  .out_overflowed    (out_overflowed)
);

// ----- sim/tb_polyline_grid_snap_simplify.sv -----
module tb_polyline_grid_snap_simplify;

  typedef struct {
    logic signed [31:0] x, y, z, m;
    logic               fin;
  } vertex_t;

  typedef struct {
    logic signed [31:0] x, y, z, m;
    logic               pt, eor, ok, ovf;
  } snap_res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [pgss_pkg::ADDR_W-1:0] paddr = '0;
  logic [pgss_pkg::DATA_W-1:0] pwdata = '0;
  logic [pgss_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] in_x = 0, in_y = 0, in_z = 0, in_m = 0;
  logic in_final_vertex = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] out_x, out_y, out_z, out_m;
  logic out_carries_point, out_end_of_run, out_geometry_ok, out_overflowed;

  polyline_grid_snap_simplify DUT (.*);

  always #5 clk = ~clk;

  // snapping state
  longint sp [4];
  bit hz, hm, dcol;
  longint kx [64], ky [64], kz [64], km [64];
  int     nkept, nin;
  longint prevr [4], first [3];
  bit     ovf_flag;

  vertex_t   pending_q [$];
  snap_res_t expected_q [$];
  int errors = 0;
  int cycles = 0;
  bit hold_send = 0;
  bit stim_done = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint grid_round(longint v, longint s);
    longint a, q, r;
    if (s == 0) return sat32(v);
    a = v < 0 ? -v : v;
    q = a / s;
    r = a % s;
    if (2 * r >= s) q++;
    return sat32(v < 0 ? -(q * s) : q * s);
  endfunction

  // exact cross product; 33-bit diffs fit in 128-bit signed math
  function automatic bit collinear(longint px, longint py, longint ax, longint ay,
                                   longint bx, longint by);
    logic signed [127:0] a, b;
    a = 128'(px - ax) * 128'(by - ay);
    b = 128'(bx - ax) * 128'(py - ay);
    return a == b;
  endfunction

  function automatic void clear_run();
    nkept = 0; nin = 0; ovf_flag = 0;
    foreach (prevr[i]) prevr[i] = 0;
    foreach (first[i]) first[i] = 0;
  endfunction

  function automatic void keep(longint x, longint y, longint z, longint m);
    if (nkept >= 64) begin
      ovf_flag = 1;
      return;
    end
    kx[nkept] = x; ky[nkept] = y; kz[nkept] = z; km[nkept] = m;
    nkept++;
  endfunction

  function automatic void predict_vertex(vertex_t v);
    longint rwx, rwy, rwz, rwm, rx, ry, rz, rm;
    bit flat, same, closed, removed, ok;
    int n, cnt, idx;
    snap_res_t r;
    rwx = v.x; rwy = v.y;
    rwz = hz ? longint'(v.z) : 0;
    rwm = hm ? longint'(v.m) : 0;
    rx = grid_round(rwx, sp[0]);
    ry = grid_round(rwy, sp[1]);
    rz = hz ? grid_round(rwz, sp[2]) : 0;
    rm = hm ? grid_round(rwm, sp[3]) : 0;
    flat = !hz && !hm;
    if (nin == 0) begin
      first[0] = rwx; first[1] = rwy; first[2] = rwz;
      keep(rx, ry, rz, rm);
      prevr[0] = rx; prevr[1] = ry; prevr[2] = rz; prevr[3] = rm;
    end else begin
      same = rx == prevr[0] && ry == prevr[1] && (!hz || sp[2] == 0 || rz == prevr[2])
             && (!hm || sp[3] == 0 || rm == prevr[3]);
      if (!same) begin
        n = nkept;
        if (dcol && n > 1 && flat &&
            collinear(kx[n-1], ky[n-1], kx[n-2], ky[n-2], rx, ry)) begin
          kx[n-1] = rx; ky[n-1] = ry;
        end else
          keep(rx, ry, rz, rm);
        prevr[0] = rx; prevr[1] = ry; prevr[2] = rz; prevr[3] = rm;
      end
    end
    if (nin < 65535) nin++;
    if (!v.fin) return;
    if (nin < 2 || nkept == 0) begin
      r = '{0, 0, 0, 0, 0, 1, 0, 0};
      expected_q.push_back(r);
      clear_run();
      return;
    end
    closed = first[0] == rwx && first[1] == rwy && (!hz || first[2] == rwz);
    n = nkept;
    removed = dcol && closed && n > 4 && flat &&
              collinear(kx[0], ky[0], kx[n-2], ky[n-2], kx[1], ky[1]);
    ok = n >= 4 || (!closed && n >= 2);
    cnt = removed ? n - 1 : n;
    for (int k = 0; k < cnt; k++) begin
      idx = removed ? (k == cnt - 1 ? 1 : k + 1) : k;
      r.x = 32'(kx[idx]); r.y = 32'(ky[idx]); r.z = 32'(kz[idx]); r.m = 32'(km[idx]);
      r.pt = 1'b1; r.eor = k == cnt - 1; r.ok = ok; r.ovf = ovf_flag;
      expected_q.push_back(r);
    end
    clear_run();
  endfunction

  task automatic report(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_valid && in_ready) begin
      predict_vertex(pending_q.pop_front());
    end
    if (!rst_n || hold_send) begin
      if (in_valid && in_ready) in_valid <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 0;
      end else if (pending_q.size() != 0) begin
        in_valid <= 1;
        in_x <= pending_q[0].x; in_y <= pending_q[0].y;
        in_z <= pending_q[0].z; in_m <= pending_q[0].m;
        in_final_vertex <= pending_q[0].fin;
        send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      end else
        in_valid <= 0;
    end
  end

  // monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    snap_res_t e;
    if (out_valid && out_ready) begin
      if (expected_q.size() == 0)
        report("result transfer with nothing expected");
      else begin
        e = expected_q.pop_front();
        if (out_x !== e.x) report($sformatf("x %0d exp %0d", out_x, e.x));
        if (out_y !== e.y) report($sformatf("y %0d exp %0d", out_y, e.y));
        if (out_z !== e.z) report($sformatf("z %0d exp %0d", out_z, e.z));
        if (out_m !== e.m) report($sformatf("m %0d exp %0d", out_m, e.m));
        if (out_carries_point !== e.pt) report("carries_point");
        if (out_end_of_run !== e.eor) report("end_of_run");
        if (out_geometry_ok !== e.ok) report("geometry_ok");
        if (out_overflowed !== e.ovf) report("overflowed");
      end
    end
    if (!rst_n) out_ready <= 0;
    else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      out_ready <= 0;
    end else
      out_ready <= 1;
  end

  always @(posedge clk) begin
    if (cycles > 2000000) begin
      $display("[polyline_grid_snap_simplify] ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= pgss_pkg::ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      pgss_pkg::REG_X_SPACING:   sp[0] = longint'(val[30:0]);
      pgss_pkg::REG_Y_SPACING:   sp[1] = longint'(val[30:0]);
      pgss_pkg::REG_Z_SPACING:   sp[2] = longint'(val[30:0]);
      pgss_pkg::REG_M_SPACING:   sp[3] = longint'(val[30:0]);
      pgss_pkg::REG_HAS_Z:       hz = val[0];
      pgss_pkg::REG_HAS_M:       hm = val[0];
      pgss_pkg::REG_DROP_COLLIN: dcol = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic void add_vtx(logic [31:0] x, y, z, m, logic fin);
    vertex_t v;
    v.x = x; v.y = y; v.z = z; v.m = m; v.fin = fin;
    pending_q.push_back(v);
  endfunction

  // polyline with random content; closed rings and straight runs are common
  function automatic void add_run(int len);
    logic [31:0] fx, fy, fz, x, y, dx, dy;
    bit ring, line;
    ring = $urandom_range(0, 2) == 0;
    line = $urandom_range(0, 1);
    fx = rand_coord(); fy = rand_coord(); fz = rand_coord();
    dx = $urandom_range(0, 20); dy = $urandom_range(0, 20);
    x = fx; y = fy;
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        if (line) begin x += dx; y += dy; end
        else if ($urandom_range(0, 3) == 0) ;
        else begin x = rand_coord(); y = rand_coord(); end
      end
      if (ring && i == len - 1)
        add_vtx(fx, fy, fz, rand_coord(), 1);
      else
        add_vtx(x, y, i == 0 ? fz : rand_coord(), rand_coord(), i == len - 1);
    end
  endfunction

  int sent;

  initial begin
    foreach (sp[i]) sp[i] = 0;
    hz = 0; hm = 0; dcol = 0;
    clear_run();
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, single vertex, repeats, ring with collinear start
    add_vtx(32'h7fffffff, 32'h80000000, 0, 0, 1);
    add_vtx(5, 5, 0, 0, 0); add_vtx(5, 5, 0, 0, 1);
    add_vtx(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'hffffffff, 0);
    add_vtx(32'h7fffffff, 32'h80000000, 0, 0, 1);
    wait_drained();
    cfg_write(pgss_pkg::REG_X_SPACING, 10); cfg_write(pgss_pkg::REG_Y_SPACING, 32'h7fffffff);
    cfg_write(pgss_pkg::REG_DROP_COLLIN, 1);
    add_vtx(5, 0, 0, 0, 0); add_vtx(-5, 0, 0, 0, 0); add_vtx(15, 0, 0, 0, 0);
    add_vtx(32'h7ffffffb, 32'h40000000, 0, 0, 0); add_vtx(-24, 32'hc0000000, 0, 0, 1);
    wait_drained();
    cfg_write(pgss_pkg::REG_Y_SPACING, 1);
    // ring: 0,0 10,0 20,0 20,10 -10,10 -10,0 0,0; the start lies between -10,0 and 20,0
    add_vtx(0, 0, 0, 0, 0); add_vtx(10, 0, 0, 0, 0); add_vtx(20, 0, 0, 0, 0);
    add_vtx(20, 10, 0, 0, 0); add_vtx(-10, 10, 0, 0, 0); add_vtx(-10, 0, 0, 0, 0);
    add_vtx(0, 0, 0, 0, 1);
    wait_drained();
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_write(pgss_pkg::REG_X_SPACING, ph == 3 ? 32'h7fffffff : $urandom_range(0, 8));
      cfg_write(pgss_pkg::REG_Y_SPACING, $urandom_range(0, 8));
      cfg_write(pgss_pkg::REG_Z_SPACING, ph == 0 ? 0 : $urandom());
      cfg_write(pgss_pkg::REG_M_SPACING, ph == 1 ? 32'h7fffffff : $urandom_range(0, 5));
      cfg_write(pgss_pkg::REG_HAS_Z, ph[0]);
      cfg_write(pgss_pkg::REG_HAS_M, ph[1]);
      cfg_write(pgss_pkg::REG_DROP_COLLIN, ph != 1);
      for (int j = 0; j < 8; j++) begin
        add_run($urandom_range(1, 9));
        if (j == 4) begin
          // sender stops with items pending until every expected result is out
          hold_send = 1;
          while (in_valid) @(posedge clk);
          while (expected_q.size() != 0) @(posedge clk);
          hold_send = 0;
        end
      end
      if (ph == 2) begin
        wait_drained();
        cfg_write(pgss_pkg::REG_DROP_COLLIN, 0);
        for (int i = 0; i < 70; i++) add_vtx(i, i * 3, 0, 0, i == 69);
      end
      wait_drained();
    end
    stim_done = 1;
    if (errors == 0) $display("[polyline_grid_snap_simplify] OK");
    else $display("[polyline_grid_snap_simplify] ERROR");
    $finish;
  end

endmodule
